// File: hw/rtl/bump_and_go_navigation_fsm_unit_assert.svh
// Assertion macros shared by the bump-and-go navigation RTL.
`ifndef BUMP_AND_GO_NAVIGATION_FSM_UNIT_ASSERT_SVH
`define BUMP_AND_GO_NAVIGATION_FSM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BGN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bgn assertion failed");

// Next-cycle implication, disabled while in reset.
`define BGN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bgn assertion failed");

`endif

// File: hw/rtl/bgn_pkg.sv
// Types and constants of the bump-and-go navigation unit.
package bgn_pkg;

    // Navigation states
    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_BACK    = 2'd1,
        MODE_TURN    = 2'd2,
        MODE_STOP    = 2'd3
    } mode_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_LINEAR_SPEED   = 3'd0,
        REG_ANGULAR_SPEED  = 3'd1,
        REG_OBSTACLE_LIMIT = 3'd2,
        REG_BACKING_TICKS  = 3'd3,
        REG_SCAN_TIMEOUT   = 3'd4,
        REG_BEAMS_PER_SCAN = 3'd5,
        REG_TURN_PER_BEAM  = 3'd6
    } reg_idx_t;

    // Input selector
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_BEAM = 1'b1;

    localparam int          CNT_W      = 20;
    localparam int          TLIM_W     = 18;
    localparam logic [19:0] CNT_MAX    = 20'hFFFFF;
    localparam logic [15:0] RANGE_NONE = 16'hFFFF;

    // Reset values of the registers
    localparam logic [15:0] RST_OBSTACLE_LIMIT = 16'd500;
    localparam logic [19:0] RST_BACKING_TICKS  = 20'd40;
    localparam logic [19:0] RST_SCAN_TIMEOUT   = 20'd20;
    localparam logic [10:0] RST_BEAMS_PER_SCAN = 11'd360;
    localparam logic [15:0] RST_TURN_PER_BEAM  = 16'd256;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [14:0] linear_speed;
        logic [14:0] angular_speed;
        logic [15:0] obstacle_limit;
        logic [19:0] backing_ticks;
        logic [19:0] scan_timeout_ticks;
        logic [10:0] beams_per_scan;
        logic [15:0] turn_ticks_per_beam;
    } cfg_t;

endpackage

// File: hw/rtl/bump_and_go_navigation_fsm_unit.sv
// Bump-and-go navigation unit: scan tracking, drive state machine, stream ports.
// An accepted word waits in the input register; any drive word it yields is loaded
// into the result register. Throughput: one word per cycle, beams and ticks alike,
// while the result slot is free or being taken; the input register and the result
// register each hold one word, and the state update is a single pass between.
// Reset (rst_n, asynchronous, active low) resets all but the data registers at once;
// no result appears until the final beam of a scan has been taken.
`include "bump_and_go_navigation_fsm_unit_assert.svh"

module bump_and_go_navigation_fsm_unit
#(
    parameter int MAX_BEAMS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] beam_range
    input  logic        s_tuser,    // [0] func
    input  logic        s_tlast,    // beam_last
    // Master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [15:0] linear_drive, [31:16] angular_drive,
                                    // [33:32] mode, [39:34] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(MAX_BEAMS);
    localparam int CMP_W = (IDX_W > 10) ? IDX_W : 10;
    localparam int PRD_W = IDX_W + 17;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BEAMS - 1);

    bgn_pkg::cfg_t cfg;

    bgn_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic        in_v_reg,  in_v_next;
    logic        in_func_reg;
    logic [15:0] in_range_reg;
    logic        in_last_reg;
    logic        s_take;
    logic        adv;

    // Scan and navigation state
    bgn_pkg::mode_t       mode_reg,  mode_next;
    logic [19:0]          ticks_reg, ticks_next;
    logic [19:0]          age_reg,   age_next;
    logic                 seen_reg,  seen_next;
    logic [IDX_W-1:0]     bidx_reg,  bidx_next;
    logic [15:0]          rmax_reg,  rmax_next;
    logic [IDX_W-1:0]     rarg_reg,  rarg_next;
    logic [15:0]          rcen_reg,  rcen_next;
    logic [IDX_W-1:0]     sarg_reg,  sarg_next;
    logic [15:0]          scen_reg,  scen_next;
    logic                 tpos_reg,  tpos_next;
    logic [17:0]          tlim_reg,  tlim_next;

    // Result register
    logic                 out_v_reg, out_v_next;
    logic signed [15:0]   lin_reg,   lin_next;
    logic signed [15:0]   ang_reg,   ang_next;
    bgn_pkg::mode_t       omode_reg;

    // Datapath helpers
    logic [CMP_W-1:0]     half_w;
    logic [IDX_W-1:0]     centre;
    logic [19:0]          ticks_inc;
    logic [19:0]          age_inc;
    logic [IDX_W-1:0]     off;
    logic [PRD_W-1:0]     rnd_sum;
    logic [PRD_W-1:0]     rnd_sh;
    logic                 is_beam;
    logic                 is_tick;
    logic                 produce;

    // Handshake: the input register drains whenever the result slot is free
    assign adv      = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || adv;
    assign s_take   = s_tvalid && s_tready;
    assign is_beam  = adv && (in_func_reg == bgn_pkg::FUNC_BEAM);
    assign is_tick  = adv && (in_func_reg == bgn_pkg::FUNC_TICK);
    assign produce  = is_tick && seen_reg;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (s_take)
            in_v_next = 1'b1;
        else if (adv)
            in_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else
            in_v_reg <= in_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_func_reg  <= s_tuser;
            in_range_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    // Centre beam index, clamped to the last index
    assign half_w = CMP_W'(cfg.beams_per_scan[10:1]);
    assign centre = (half_w > CMP_W'(MAX_BEAMS - 1)) ? IDX_LAST : IDX_W'(half_w);

    // Saturating counters
    assign ticks_inc = (ticks_reg != bgn_pkg::CNT_MAX) ? ticks_reg + 20'd1 : ticks_reg;
    assign age_inc   = (age_reg != bgn_pkg::CNT_MAX) ? age_reg + 20'd1 : age_reg;

    // Turn time: beam offset times Q8.8 factor, rounded half up
    assign off     = (sarg_reg > centre) ? sarg_reg - centre : centre - sarg_reg;
    assign rnd_sum = PRD_W'(off) * PRD_W'(cfg.turn_ticks_per_beam) + PRD_W'(128);
    assign rnd_sh  = rnd_sum >> 8;

    // Scan tracking
    always_comb
    begin
        bidx_next = bidx_reg;
        rmax_next = rmax_reg;
        rarg_next = rarg_reg;
        rcen_next = rcen_reg;
        sarg_next = sarg_reg;
        scen_next = scen_reg;
        seen_next = seen_reg;
        if (is_beam)
        begin
            if (in_range_reg > rmax_reg)
            begin
                rmax_next = in_range_reg;
                rarg_next = bidx_reg;
            end
            if (bidx_reg == centre)
                rcen_next = in_range_reg;
            if (in_last_reg)
            begin
                sarg_next = rarg_next;
                scen_next = rcen_next;
                seen_next = 1'b1;
                bidx_next = '0;
                rmax_next = '0;
                rarg_next = '0;
                rcen_next = bgn_pkg::RANGE_NONE;
            end
            else if (bidx_reg != IDX_LAST)
            begin
                bidx_next = bidx_reg + IDX_W'(1);
            end
        end
    end

    // Navigation state machine: next state, counters and drive values
    always_comb
    begin
        mode_next  = mode_reg;
        ticks_next = ticks_reg;
        age_next   = age_reg;
        tpos_next  = tpos_reg;
        tlim_next  = tlim_reg;
        lin_next   = lin_reg;
        ang_next   = ang_reg;
        if (is_beam && in_last_reg)
            age_next = '0;
        if (is_tick)
        begin
            ticks_next = ticks_inc;
            age_next   = age_inc;
        end
        if (produce)
        begin
            lin_next = '0;
            ang_next = '0;
            unique case (mode_reg)
                bgn_pkg::MODE_FORWARD:
                begin
                    lin_next = {1'b0, cfg.linear_speed};
                    if (age_inc > cfg.scan_timeout_ticks)
                        mode_next = bgn_pkg::MODE_STOP;
                    if (scen_reg < cfg.obstacle_limit)
                        mode_next = bgn_pkg::MODE_BACK;
                end
                bgn_pkg::MODE_BACK:
                begin
                    lin_next = 16'sd0 - signed'({1'b0, cfg.linear_speed});
                    if (ticks_inc > cfg.backing_ticks)
                    begin
                        tpos_next = sarg_reg > centre;
                        tlim_next = bgn_pkg::TLIM_W'(rnd_sh);
                        mode_next = bgn_pkg::MODE_TURN;
                    end
                end
                bgn_pkg::MODE_TURN:
                begin
                    ang_next = tpos_reg ? signed'({1'b0, cfg.angular_speed})
                                        : 16'sd0 - signed'({1'b0, cfg.angular_speed});
                    if (ticks_inc > 20'(tlim_reg))
                        mode_next = bgn_pkg::MODE_FORWARD;
                end
                bgn_pkg::MODE_STOP:
                begin
                    if (age_inc < cfg.scan_timeout_ticks)
                        mode_next = bgn_pkg::MODE_FORWARD;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
            if (mode_next != mode_reg)
                ticks_next = '0;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= bgn_pkg::MODE_FORWARD;
        else
            mode_reg <= mode_next;
    end

    // Counters and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= '0;
            age_reg   <= '0;
            seen_reg  <= 1'b0;
            bidx_reg  <= '0;
            rmax_reg  <= '0;
            rarg_reg  <= '0;
            rcen_reg  <= bgn_pkg::RANGE_NONE;
            sarg_reg  <= '0;
            scen_reg  <= bgn_pkg::RANGE_NONE;
            tpos_reg  <= 1'b0;
            tlim_reg  <= '0;
        end
        else
        begin
            ticks_reg <= ticks_next;
            age_reg   <= age_next;
            seen_reg  <= seen_next;
            bidx_reg  <= bidx_next;
            rmax_reg  <= rmax_next;
            rarg_reg  <= rarg_next;
            rcen_reg  <= rcen_next;
            sarg_reg  <= sarg_next;
            scen_reg  <= scen_next;
            tpos_reg  <= tpos_next;
            tlim_reg  <= tlim_next;
        end
    end

    // Result register
    always_comb
    begin
        out_v_next = out_v_reg;
        if (adv)
            out_v_next = produce;
        else if (m_tready)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= out_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            lin_reg   <= lin_next;
            ang_reg   <= ang_next;
            omode_reg <= mode_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, omode_reg, ang_reg, lin_reg};

    // Checks on the control logic
    `BGN_ASSERT_IMPL(a_result_after_scan, clk, rst_n, out_v_reg, seen_reg)
    `BGN_ASSERT_IMPL(a_one_drive_active, clk, rst_n, out_v_reg && (lin_reg != 16'sd0),
                     ang_reg == 16'sd0)
    `BGN_ASSERT_IMPL(a_stall_holds_input, clk, rst_n, !s_tready, in_v_reg && out_v_reg)
    `BGN_ASSERT_NEXT(a_change_clears_ticks, clk, rst_n,
                     produce && (mode_next != mode_reg), ticks_reg == 20'd0)

endmodule

// File: hw/rtl/bgn_regs.sv
// APB register file holding the navigation configuration.
module bgn_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bgn_pkg::cfg_t cfg
);

    bgn_pkg::cfg_t  cfg_reg;
    bgn_pkg::cfg_t  cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                bgn_pkg::REG_LINEAR_SPEED:   cfg_next.linear_speed        = pwdata[14:0];
                bgn_pkg::REG_ANGULAR_SPEED:  cfg_next.angular_speed       = pwdata[14:0];
                bgn_pkg::REG_OBSTACLE_LIMIT: cfg_next.obstacle_limit      = pwdata[15:0];
                bgn_pkg::REG_BACKING_TICKS:  cfg_next.backing_ticks       = pwdata[19:0];
                bgn_pkg::REG_SCAN_TIMEOUT:   cfg_next.scan_timeout_ticks  = pwdata[19:0];
                bgn_pkg::REG_BEAMS_PER_SCAN: cfg_next.beams_per_scan      = pwdata[10:0];
                bgn_pkg::REG_TURN_PER_BEAM:  cfg_next.turn_ticks_per_beam = pwdata[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_speed        <= '0;
            cfg_reg.angular_speed       <= '0;
            cfg_reg.obstacle_limit      <= bgn_pkg::RST_OBSTACLE_LIMIT;
            cfg_reg.backing_ticks       <= bgn_pkg::RST_BACKING_TICKS;
            cfg_reg.scan_timeout_ticks  <= bgn_pkg::RST_SCAN_TIMEOUT;
            cfg_reg.beams_per_scan      <= bgn_pkg::RST_BEAMS_PER_SCAN;
            cfg_reg.turn_ticks_per_beam <= bgn_pkg::RST_TURN_PER_BEAM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            bgn_pkg::REG_LINEAR_SPEED:   prdata = {17'd0, cfg_reg.linear_speed};
            bgn_pkg::REG_ANGULAR_SPEED:  prdata = {17'd0, cfg_reg.angular_speed};
            bgn_pkg::REG_OBSTACLE_LIMIT: prdata = {16'd0, cfg_reg.obstacle_limit};
            bgn_pkg::REG_BACKING_TICKS:  prdata = {12'd0, cfg_reg.backing_ticks};
            bgn_pkg::REG_SCAN_TIMEOUT:   prdata = {12'd0, cfg_reg.scan_timeout_ticks};
            bgn_pkg::REG_BEAMS_PER_SCAN: prdata = {21'd0, cfg_reg.beams_per_scan};
            bgn_pkg::REG_TURN_PER_BEAM:  prdata = {16'd0, cfg_reg.turn_ticks_per_beam};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

// File: test/bump_and_go_navigation_fsm_unit_tb.sv
// Self-checking testbench for the navigation unit: stream and APB stimulus, shadow model.
module bump_and_go_navigation_fsm_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BEAM_TOP    = 1023;
    localparam int          HOLD_CYCLES = 80;
    localparam int          SETTLE      = 8;
    localparam logic [4:0]  UNUSED_ADDR = 5'd28;
    localparam logic        TICK        = bgn_pkg::FUNC_TICK;
    localparam logic        BEAM        = bgn_pkg::FUNC_BEAM;

    // One drive word as seen on m_tdata
    typedef struct packed {
        logic [15:0]    lin;
        logic [15:0]    ang;
        bgn_pkg::mode_t mode;
    } drive_t;

    localparam drive_t NO_DRIVE = '{16'h0000, 16'h0000, bgn_pkg::MODE_FORWARD};

    // Directed row: input word, plus a hand-written result where it is obvious
    typedef struct packed {
        logic        func;
        logic [15:0] range_mm;
        logic        last;
        logic        typed;
        logic        has_res;
        drive_t      res;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Tags travelling with the word on the input side
    logic        row_typed = 1'b0;
    logic        row_has = 1'b0;
    drive_t      row_res = NO_DRIVE;

    // Receiver control
    bit          tx_gaps_on = 1'b1;
    logic        rx_gaps_on = 1'b1;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          rx_wait = 0;

    int          err_cnt = 0;
    drive_t      drive_q [$];

    // Shadow copy of the configuration and the navigation state
    bgn_pkg::cfg_t  nav_cfg;
    bgn_pkg::mode_t nav_mode;
    logic [19:0]    mode_ticks;
    logic [19:0]    scan_age;
    bit             scan_seen;
    bit             turn_pos;
    logic [9:0]     beam_idx;
    logic [9:0]     run_arg;
    logic [9:0]     scan_arg;
    logic [15:0]    run_max;
    logic [15:0]    run_ctr;
    logic [15:0]    scan_ctr;
    logic [17:0]    turn_lim;

    // Directed words: reset behaviour, extremes, ties, missing centre, timeout
    probe_row_t probe_tab [25] = '{
        // no result before the first complete scan
        '{TICK, 16'h1234, 1'b1, 1'b1, 1'b0, NO_DRIVE},
        '{TICK, 16'hEDCB, 1'b0, 1'b1, 1'b0, NO_DRIVE},
        // tied maxima at full range keep index 0, centre beam close in
        '{BEAM, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{BEAM, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{BEAM, 16'd100,  1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{BEAM, 16'h0000, 1'b1, 1'b0, 1'b0, NO_DRIVE},
        // obstacle: forward at full speed, then reverse
        '{TICK, 16'h0000, 1'b0, 1'b1, 1'b1, '{16'h7FFF, 16'h0000, bgn_pkg::MODE_BACK}},
        '{TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1, '{16'h8001, 16'h0000, bgn_pkg::MODE_BACK}},
        '{TICK, 16'h5555, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'hAAAA, 1'b1, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'h0001, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'h8000, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'h7FFF, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        // scan that ends before the centre beam
        '{BEAM, 16'd5000, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{BEAM, 16'd7000, 1'b1, 1'b0, 1'b0, NO_DRIVE},
        // scan ages out: forward then stop
        '{TICK, 16'h0F0F, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'hF0F0, 1'b1, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'h00FF, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'hFF00, 1'b0, 1'b1, 1'b1, '{16'h7FFF, 16'h0000, bgn_pkg::MODE_STOP}},
        '{TICK, 16'h3C3C, 1'b1, 1'b0, 1'b0, NO_DRIVE},
        // fresh scan, maximum past the centre, then back to forward
        '{BEAM, 16'h0000, 1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{BEAM, 16'd3,    1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{BEAM, 16'd600,  1'b0, 1'b0, 1'b0, NO_DRIVE},
        '{BEAM, 16'hFFFF, 1'b1, 1'b0, 1'b0, NO_DRIVE},
        '{TICK, 16'hC3C3, 1'b0, 1'b1, 1'b1, '{16'h0000, 16'h0000, bgn_pkg::MODE_FORWARD}}
    };

    bump_and_go_navigation_fsm_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // Counts a fault; true while it should still be reported
    function automatic bit log_fault();
        err_cnt++;
        return err_cnt <= 10;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Shadow state back to its reset values
    function automatic void nav_reset();
        nav_cfg.linear_speed        = '0;
        nav_cfg.angular_speed       = '0;
        nav_cfg.obstacle_limit      = bgn_pkg::RST_OBSTACLE_LIMIT;
        nav_cfg.backing_ticks       = bgn_pkg::RST_BACKING_TICKS;
        nav_cfg.scan_timeout_ticks  = bgn_pkg::RST_SCAN_TIMEOUT;
        nav_cfg.beams_per_scan      = bgn_pkg::RST_BEAMS_PER_SCAN;
        nav_cfg.turn_ticks_per_beam = bgn_pkg::RST_TURN_PER_BEAM;
        nav_mode   = bgn_pkg::MODE_FORWARD;
        mode_ticks = '0;
        scan_age   = '0;
        scan_seen  = 1'b0;
        turn_pos   = 1'b0;
        beam_idx   = '0;
        run_max    = '0;
        run_arg    = '0;
        run_ctr    = bgn_pkg::RANGE_NONE;
        scan_arg   = '0;
        scan_ctr   = bgn_pkg::RANGE_NONE;
        turn_lim   = '0;
    endfunction

    function automatic void cfg_store(bgn_pkg::reg_idx_t idx, logic [31:0] v);
        case (idx)
            bgn_pkg::REG_LINEAR_SPEED:   nav_cfg.linear_speed        = v[14:0];
            bgn_pkg::REG_ANGULAR_SPEED:  nav_cfg.angular_speed       = v[14:0];
            bgn_pkg::REG_OBSTACLE_LIMIT: nav_cfg.obstacle_limit      = v[15:0];
            bgn_pkg::REG_BACKING_TICKS:  nav_cfg.backing_ticks       = v[19:0];
            bgn_pkg::REG_SCAN_TIMEOUT:   nav_cfg.scan_timeout_ticks  = v[19:0];
            bgn_pkg::REG_BEAMS_PER_SCAN: nav_cfg.beams_per_scan      = v[10:0];
            bgn_pkg::REG_TURN_PER_BEAM:  nav_cfg.turn_ticks_per_beam = v[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] cfg_value(bgn_pkg::reg_idx_t idx);
        case (idx)
            bgn_pkg::REG_LINEAR_SPEED:   return 32'(nav_cfg.linear_speed);
            bgn_pkg::REG_ANGULAR_SPEED:  return 32'(nav_cfg.angular_speed);
            bgn_pkg::REG_OBSTACLE_LIMIT: return 32'(nav_cfg.obstacle_limit);
            bgn_pkg::REG_BACKING_TICKS:  return 32'(nav_cfg.backing_ticks);
            bgn_pkg::REG_SCAN_TIMEOUT:   return 32'(nav_cfg.scan_timeout_ticks);
            bgn_pkg::REG_BEAMS_PER_SCAN: return 32'(nav_cfg.beams_per_scan);
            bgn_pkg::REG_TURN_PER_BEAM:  return 32'(nav_cfg.turn_ticks_per_beam);
            default:                     return 32'h0;
        endcase
    endfunction

    function automatic void go_to(bgn_pkg::mode_t m);
        nav_mode   = m;
        mode_ticks = '0;
    endfunction

    // Advances the shadow state by one word; true when a drive word results
    function automatic bit nav_step(logic func, logic [15:0] rng, logic last,
                                    output drive_t res);
        logic [10:0] half;
        logic [9:0]  ctr;
        logic [9:0]  off;
        logic [26:0] prod;
        res  = NO_DRIVE;
        half = nav_cfg.beams_per_scan >> 1;
        if (half > BEAM_TOP)
            half = BEAM_TOP;
        ctr = half[9:0];

        // beam: first maximum, centre capture, commit on the final beam
        if (func == bgn_pkg::FUNC_BEAM)
        begin
            if (rng > run_max)
            begin
                run_max = rng;
                run_arg = beam_idx;
            end
            if (beam_idx == ctr)
                run_ctr = rng;
            if (last)
            begin
                scan_arg  = run_arg;
                scan_ctr  = run_ctr;
                scan_seen = 1'b1;
                scan_age  = '0;
                beam_idx  = '0;
                run_max   = '0;
                run_arg   = '0;
                run_ctr   = bgn_pkg::RANGE_NONE;
            end
            else if (beam_idx < BEAM_TOP)
                beam_idx++;
            return 1'b0;
        end

        // tick: saturating counters, then one step of the state machine
        if (mode_ticks != bgn_pkg::CNT_MAX)
            mode_ticks++;
        if (scan_age != bgn_pkg::CNT_MAX)
            scan_age++;
        if (!scan_seen)
            return 1'b0;

        case (nav_mode)
            bgn_pkg::MODE_FORWARD:
            begin
                res.lin = {1'b0, nav_cfg.linear_speed};
                if (scan_age > nav_cfg.scan_timeout_ticks)
                    go_to(bgn_pkg::MODE_STOP);
                if (scan_ctr < nav_cfg.obstacle_limit)
                    go_to(bgn_pkg::MODE_BACK);
            end
            bgn_pkg::MODE_BACK:
            begin
                res.lin = 16'h0000 - {1'b0, nav_cfg.linear_speed};
                if (mode_ticks > nav_cfg.backing_ticks)
                begin
                    off      = (scan_arg > ctr) ? scan_arg - ctr : ctr - scan_arg;
                    turn_pos = scan_arg > ctr;
                    prod     = 27'(off) * 27'(nav_cfg.turn_ticks_per_beam) + 27'd128;
                    turn_lim = prod[25:8];
                    go_to(bgn_pkg::MODE_TURN);
                end
            end
            bgn_pkg::MODE_TURN:
            begin
                res.ang = turn_pos ? {1'b0, nav_cfg.angular_speed}
                                   : 16'h0000 - {1'b0, nav_cfg.angular_speed};
                if (mode_ticks > {2'b00, turn_lim})
                    go_to(bgn_pkg::MODE_FORWARD);
            end
            default:
            begin
                if (scan_age < nav_cfg.scan_timeout_ticks)
                    go_to(bgn_pkg::MODE_FORWARD);
            end
        endcase
        res.mode = nav_mode;
        return 1'b1;
    endfunction

    // Input side: shadow step on every accepted word; output side: compare
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        drive_t pred;
        bit     has;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.lin  = m_tdata[15:0];
                got.ang  = m_tdata[31:16];
                got.mode = bgn_pkg::mode_t'(m_tdata[33:32]);
                if (drive_q.size() == 0)
                begin
                    if (log_fault())
                        $display("unexpected drive word: lin %h ang %h mode %0d",
                                 got.lin, got.ang, got.mode);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.lin !== want.lin || got.ang !== want.ang || got.mode !== want.mode)
                    begin
                        if (log_fault())
                            $display("drive mismatch: expected lin %h ang %h mode %0d,",
                                     want.lin, want.ang, want.mode,
                                     " got lin %h ang %h mode %0d",
                                     got.lin, got.ang, got.mode);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                has = nav_step(s_tuser, s_tdata, s_tlast, pred);
                if (row_typed)
                begin
                    if (row_has)
                        drive_q.push_back(row_res);
                end
                else if (has)
                    drive_q.push_back(pred);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (rx_wait != 0)
        begin
            rx_wait  <= rx_wait - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rx_gaps_on && $urandom_range(0, 2) == 0)
                rx_wait <= pick_gap();
        end
    end

    // APB transfer: setup then access; returns read data sampled at the access edge
    task automatic apb_access(input bit wr, input logic [4:0] addr, input logic [31:0] data,
                              output logic [31:0] rd);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes every register, pokes the unused address, reads all back
    task automatic set_config(input logic [31:0] ls, input logic [31:0] as,
                              input logic [31:0] ol, input logic [31:0] bt,
                              input logic [31:0] st, input logic [31:0] bps,
                              input logic [31:0] tpb);
        logic [31:0]       v [7];
        logic [31:0]       rd;
        bgn_pkg::reg_idx_t idx;
        v[0] = ls;
        v[1] = as;
        v[2] = ol;
        v[3] = bt;
        v[4] = st;
        v[5] = bps;
        v[6] = tpb;
        for (int r = 0; r < 7; r++)
        begin
            idx = bgn_pkg::reg_idx_t'(r);
            apb_access(1'b1, {idx, 2'b00}, v[r], rd);
            cfg_store(idx, v[r]);
        end
        apb_access(1'b1, UNUSED_ADDR, $urandom, rd);
        for (int r = 0; r < 7; r++)
        begin
            idx = bgn_pkg::reg_idx_t'(r);
            apb_access(1'b0, {idx, 2'b00}, 32'h0, rd);
            if (rd !== cfg_value(idx))
            begin
                if (log_fault())
                    $display("register %0d readback: expected %h, got %h",
                             r, cfg_value(idx), rd);
            end
        end
    endtask

    // Offers one word and waits for it to be taken
    task automatic send_word(input logic func, input logic [15:0] rng, input logic last,
                             input bit typed, input bit has, input drive_t res);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= func;
        s_tdata   <= rng;
        s_tlast   <= last;
        row_typed <= typed;
        row_has   <= has;
        row_res   <= res;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_plain(input logic func, input logic [15:0] rng, input logic last);
        send_word(func, rng, last, 1'b0, 1'b0, NO_DRIVE);
    endtask

    // Beam ranges: full spread, near the obstacle limit, extremes
    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 1000));
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            3:       return nav_cfg.obstacle_limit + 16'($urandom_range(0, 4)) - 16'd2;
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_scan(input int len, input bit closed);
        for (int b = 0; b < len; b++)
            send_plain(BEAM, pick_range(), closed && (b == len - 1));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_plain(TICK, 16'($urandom), 1'($urandom));
    endtask

    // Mostly whole scans and runs of ticks; some short, long or unclosed scans
    task automatic run_traffic(input int n);
        int sent;
        int len;
        int k;
        bit closed;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 5)
            begin
                len = (nav_cfg.beams_per_scan == 0) ? 1 : int'(nav_cfg.beams_per_scan);
                if (len > 40)
                    len = $urandom_range(1, 40);
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, len + 3);
                closed = $urandom_range(0, 9) != 0;
                send_scan(len, closed);
                sent += len;
            end
            else
            begin
                k = $urandom_range(1, 12);
                send_ticks(k);
                sent += k;
            end
        end
    endtask

    // Stops offering words until every drive word is back, then lets the pipe settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        nav_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at full drive, four-beam scans
        set_config(32767, 32767, 500, 1, 3, 4, 384);
        foreach (probe_tab[i])
            send_word(probe_tab[i].func, probe_tab[i].range_mm, probe_tab[i].last,
                      probe_tab[i].typed, probe_tab[i].has_res, probe_tab[i].res);
        wait_drain();

        // mid-range settings; long receiver hold with the sender flat out
        set_config(1234, 4321, 1000, 2, 6, 8, 256);
        send_scan(8, 1'b1);
        hold_token <= hold_token + 1;
        tx_gaps_on = 1'b0;
        send_ticks(24);
        tx_gaps_on = 1'b1;
        run_traffic(100);
        wait_drain();
        run_traffic(100);
        wait_drain();

        // upper extremes, no idling on either side
        rx_gaps_on <= 1'b0;
        tx_gaps_on = 1'b0;
        set_config(32767, 32767, 65535, 0, 0, 1, 65535);
        run_traffic(100);
        wait_drain();
        rx_gaps_on <= 1'b1;
        tx_gaps_on = 1'b1;

        // all zero, centre index 0
        set_config(0, 0, 0, 0, 0, 0, 0);
        run_traffic(100);
        wait_drain();

        // widest beam count: centre at the top index, out of reach of a short scan
        set_config(1, 1, 65535, 1048575, 1048575, 2047, 255);
        send_scan(40, 1'b1);
        send_ticks(10);
        wait_drain();

        // widest regular scan, cut short so its centre is missed
        set_config(500, 600, 2000, 1, 10, 1024, 256);
        run_traffic(100);
        wait_drain();

        // random settings
        repeat (4)
        begin
            rx_gaps_on <= $urandom_range(0, 3) != 0;
            tx_gaps_on = $urandom_range(0, 3) != 0;
            set_config($urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 3000), $urandom_range(0, 6),
                       $urandom_range(0, 12), $urandom_range(1, 12),
                       $urandom_range(0, 1023));
            run_traffic(90);
            wait_drain();
        end

        if (drive_q.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
